FILE: rtl/slfr_pkg.sv
// ----------------------------------------------------------------------------
// slfr_pkg
// Types and constants for the sync / length frame receiver.
// ----------------------------------------------------------------------------
package slfr_pkg;

	// Field widths
	localparam int unsigned ByteW  = 8;
	localparam int unsigned PosW   = 17;
	localparam int unsigned HdrW   = 5;
	localparam int unsigned CfgIdxW = 8;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_SYNC_FIRST      = 8'd0;
	localparam logic [CfgIdxW-1:0] REG_SYNC_SECOND     = 8'd1;
	localparam logic [CfgIdxW-1:0] REG_HEADER_BYTES    = 8'd2;
	localparam logic [CfgIdxW-1:0] REG_SIZE_BIG_ENDIAN = 8'd3;

	// Register reset values
	localparam logic [ByteW-1:0] SyncFirstRst     = 8'd2;
	localparam logic [ByteW-1:0] SyncSecondRst    = 8'd2;
	localparam logic [HdrW-1:0]  HeaderBytesRst   = 5'd7;
	localparam logic             SizeBigEndianRst = 1'b1;

	// Fixed frame positions of the preamble bytes and of the first body byte
	localparam logic [PosW-1:0] PosSync1 = 17'd0;
	localparam logic [PosW-1:0] PosSync2 = 17'd1;
	localparam logic [PosW-1:0] PosSize1 = 17'd2;
	localparam logic [PosW-1:0] PosSize2 = 17'd3;
	localparam logic [PosW-1:0] PosData  = 17'd4;

	// Receive phase, one-hot
	typedef enum logic [4:0] {
		PH_SYNC1 = 5'b00001,
		PH_SYNC2 = 5'b00010,
		PH_SIZE1 = 5'b00100,
		PH_SIZE2 = 5'b01000,
		PH_DATA  = 5'b10000
	} phase_t;

	// One result item
	typedef struct packed {
		logic [ByteW-1:0] out_byte;
		logic             in_frame;
		logic [PosW-1:0]  frame_pos;
		logic             frame_last;
	} result_t;

endpackage

FILE: rtl/sync_length_frame_receiver.sv
// ----------------------------------------------------------------------------
// sync_length_frame_receiver
// Byte stream deframer: sync pair, two-byte size field, counted frame body.
//
// Takes one byte per item and returns one result per item, one item per clock
// sustained while out_stall stays low. Each byte goes through combinational
// phase logic into a result register; a one-entry skid register behind it
// lets the input keep taking items while a result waits, so in_stall rises
// only once both are full and does not depend on out_stall combinationally.
// Frame length is the size field plus header_bytes, at least four; every byte
// carries its frame position (first sync byte is 0) and a last mark. Indexes
// 4 and up are ignored. Configuration is written through cfg_valid/cfg_ready
// (always ready); the user writes it only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module sync_length_frame_receiver (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [slfr_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [slfr_pkg::ByteW-1:0]       cfg_data,
	// input bytes
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [slfr_pkg::ByteW-1:0]       in_byte,
	// results
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [slfr_pkg::ByteW-1:0]       out_byte,
	output logic                             in_frame,
	output logic [slfr_pkg::PosW-1:0]        frame_pos,
	output logic                             frame_last
);
	import slfr_pkg::*;

	// Configuration registers
	logic [ByteW-1:0] sync_first_q;
	logic [ByteW-1:0] sync_second_q;
	logic [HdrW-1:0]  header_bytes_q;
	logic             size_big_endian_q;

	// Receive state
	phase_t           phase_q;
	logic [PosW-1:0]  byte_count_q;
	logic [PosW-1:0]  frame_total_q;
	logic [ByteW-1:0] size_first_byte_q;

	// Result and skid registers
	result_t          out_q;
	logic             out_valid_q;
	result_t          skid_q;
	logic             skid_valid_q;

	// Next-state and result logic
	phase_t           phase_d;
	logic [PosW-1:0]  byte_count_d;
	logic [PosW-1:0]  frame_total_d;
	result_t          res;
	logic [15:0]      size_word;
	logic [PosW-1:0]  total_calc;
	logic [PosW-1:0]  count_inc;

	logic             accept;
	logic             take;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid & ~skid_valid_q;
	assign take      = out_valid_q & ~out_stall;
	assign in_stall  = skid_valid_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q      <= SyncFirstRst;
			sync_second_q     <= SyncSecondRst;
			header_bytes_q    <= HeaderBytesRst;
			size_big_endian_q <= SizeBigEndianRst;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SYNC_FIRST:      sync_first_q      <= cfg_data;
				REG_SYNC_SECOND:     sync_second_q     <= cfg_data;
				REG_HEADER_BYTES:    header_bytes_q    <= cfg_data[HdrW-1:0];
				REG_SIZE_BIG_ENDIAN: size_big_endian_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Assemble the size field and the frame total
	always_comb begin
		if (size_big_endian_q) begin
			size_word = {size_first_byte_q, in_byte};
		end else begin
			size_word = {in_byte, size_first_byte_q};
		end
		total_calc = {1'b0, size_word} + {{(PosW-HdrW){1'b0}}, header_bytes_q};
		count_inc  = byte_count_q + 17'd1;
	end

	// Phase logic for one byte
	always_comb begin
		phase_d       = phase_q;
		byte_count_d  = byte_count_q;
		frame_total_d = frame_total_q;
		res.out_byte   = in_byte;
		res.in_frame   = 1'b0;
		res.frame_pos  = PosSync1;
		res.frame_last = 1'b0;
		unique case (phase_q)
			PH_SYNC2: begin
				if (in_byte == sync_second_q) begin
					res.in_frame  = 1'b1;
					res.frame_pos = PosSync2;
					byte_count_d  = PosSize1;
					phase_d       = PH_SIZE1;
				end else begin
					byte_count_d = PosSync1;
					phase_d      = PH_SYNC1;
				end
			end
			PH_SIZE1: begin
				res.in_frame  = 1'b1;
				res.frame_pos = PosSize1;
				byte_count_d  = PosSize2;
				phase_d       = PH_SIZE2;
			end
			PH_SIZE2: begin
				res.in_frame  = 1'b1;
				res.frame_pos = PosSize2;
				frame_total_d = total_calc;
				if (total_calc <= PosData) begin
					res.frame_last = 1'b1;
					byte_count_d   = PosSync1;
					phase_d        = PH_SYNC1;
				end else begin
					byte_count_d = PosData;
					phase_d      = PH_DATA;
				end
			end
			PH_DATA: begin
				res.in_frame  = 1'b1;
				res.frame_pos = byte_count_q;
				if (count_inc >= frame_total_q) begin
					res.frame_last = 1'b1;
					byte_count_d   = PosSync1;
					phase_d        = PH_SYNC1;
				end else begin
					byte_count_d = count_inc;
				end
			end
			default: begin
				if (in_byte == sync_first_q) begin
					res.in_frame = 1'b1;
					byte_count_d = PosSync2;
					phase_d      = PH_SYNC2;
				end else begin
					byte_count_d = PosSync1;
					phase_d      = PH_SYNC1;
				end
			end
		endcase
	end

	// Advance receive state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= PH_SYNC1;
			byte_count_q      <= '0;
			frame_total_q     <= '0;
			size_first_byte_q <= '0;
		end else if (accept) begin
			phase_q       <= phase_d;
			byte_count_q  <= byte_count_d;
			frame_total_q <= frame_total_d;
			if (phase_q == PH_SIZE1) begin
				size_first_byte_q <= in_byte;
			end
		end
	end

	// Result register with skid stage behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || take) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload moves without reset
	always_ff @(posedge clk) begin
		if (!out_valid_q || take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res;
			end
		end else if (accept) begin
			skid_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_q.out_byte;
	assign in_frame   = out_q.in_frame;
	assign frame_pos  = out_q.frame_pos;
	assign frame_last = out_q.frame_last;

	// Skid entry only fills behind a held result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds an item while result register is empty");

	// Hunting bytes carry no position and no last mark
	a_discard_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.in_frame) |-> (out_q.frame_pos == '0 && !out_q.frame_last))
		else $error("discarded byte carries frame position or last mark");

	// Body count starts after the size field
	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (byte_count_q >= PosData && byte_count_q < frame_total_q))
		else $error("body byte count out of frame range");

	// A full skid stage stalls the input
	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && out_stall) |=> skid_valid_q && $stable(skid_q))
		else $error("skid item lost while output stalled");

endmodule

FILE: sim/sync_length_frame_receiver_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sync_length_frame_receiver_checker
// Watches the register, byte and result channels of the frame receiver. Keeps
// its own copy of the registers and of the deframing state, works out the
// result for every byte taken in and compares it, field by field, with the
// results that leave the block in order.
// ----------------------------------------------------------------------------
module sync_length_frame_receiver_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [slfr_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [slfr_pkg::ByteW-1:0]   cfg_data,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [slfr_pkg::ByteW-1:0]   in_byte,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [slfr_pkg::ByteW-1:0]   out_byte,
	input  logic                         in_frame,
	input  logic [slfr_pkg::PosW-1:0]    frame_pos,
	input  logic                         frame_last,
	output int                           results_owed,
	output int                           mismatches
);
	import slfr_pkg::*;

	// Shadow registers
	logic [ByteW-1:0] sync_a;
	logic [ByteW-1:0] sync_b;
	logic [HdrW-1:0]  hdr_len;
	logic             size_be;

	// Shadow deframing state
	phase_t           rx_phase;
	logic [PosW-1:0]  next_pos;
	logic [PosW-1:0]  total_len;
	logic [ByteW-1:0] size_lead;

	// Results predicted but not yet seen, oldest first
	result_t awaited_results[$];

	// Advance the shadow state by one byte and return its result
	function automatic result_t deframe(input logic [ByteW-1:0] b);
		result_t r;
		logic [15:0] size;
		r = '0;
		r.out_byte = b;
		case (rx_phase)
			PH_SYNC2: begin
				if (b == sync_b) begin
					r.in_frame  = 1'b1;
					r.frame_pos = PosSync2;
					next_pos    = PosSize1;
					rx_phase    = PH_SIZE1;
				end else begin
					// mismatch drops back to the hunt without rechecking this byte
					next_pos = '0;
					rx_phase = PH_SYNC1;
				end
			end
			PH_SIZE1: begin
				size_lead   = b;
				r.in_frame  = 1'b1;
				r.frame_pos = PosSize1;
				next_pos    = PosSize2;
				rx_phase    = PH_SIZE2;
			end
			PH_SIZE2: begin
				size        = size_be ? {size_lead, b} : {b, size_lead};
				total_len   = {1'b0, size} + hdr_len;
				r.in_frame  = 1'b1;
				r.frame_pos = PosSize2;
				// a total of four or less ends the frame on this byte
				if (total_len <= PosData) begin
					r.frame_last = 1'b1;
					next_pos     = '0;
					rx_phase     = PH_SYNC1;
				end else begin
					next_pos = PosData;
					rx_phase = PH_DATA;
				end
			end
			PH_DATA: begin
				r.in_frame  = 1'b1;
				r.frame_pos = next_pos;
				next_pos    = next_pos + 1'b1;
				if (next_pos >= total_len) begin
					r.frame_last = 1'b1;
					next_pos     = '0;
					rx_phase     = PH_SYNC1;
				end
			end
			default: begin
				if (b == sync_a) begin
					r.in_frame  = 1'b1;
					r.frame_pos = PosSync1;
					next_pos    = PosSync2;
					rx_phase    = PH_SYNC2;
				end else begin
					next_pos = '0;
					rx_phase = PH_SYNC1;
				end
			end
		endcase
		return r;
	endfunction

	// Track writes, check taken results, predict taken bytes
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		int errs;
		if (!arst_n) begin
			sync_a    = SyncFirstRst;
			sync_b    = SyncSecondRst;
			hdr_len   = HeaderBytesRst;
			size_be   = SizeBigEndianRst;
			rx_phase  = PH_SYNC1;
			next_pos  = '0;
			total_len = '0;
			size_lead = '0;
			awaited_results.delete();
			results_owed <= 0;
			mismatches   <= 0;
		end else begin
			errs = 0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SYNC_FIRST:      sync_a  = cfg_data;
					REG_SYNC_SECOND:     sync_b  = cfg_data;
					REG_HEADER_BYTES:    hdr_len = cfg_data[HdrW-1:0];
					REG_SIZE_BIG_ENDIAN: size_be = cfg_data[0];
					default: ;
				endcase
			end
			// compare against the oldest prediction
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					$error("unexpected result item: out_byte %0d", out_byte);
					errs++;
				end else begin
					want = awaited_results.pop_front();
					if (out_byte !== want.out_byte) begin
						$error("out_byte: expected %0d, got %0d", want.out_byte, out_byte);
						errs++;
					end
					if (in_frame !== want.in_frame) begin
						$error("in_frame: expected %0d, got %0d", want.in_frame, in_frame);
						errs++;
					end
					if (frame_pos !== want.frame_pos) begin
						$error("frame_pos: expected %0d, got %0d", want.frame_pos, frame_pos);
						errs++;
					end
					if (frame_last !== want.frame_last) begin
						$error("frame_last: expected %0d, got %0d", want.frame_last, frame_last);
						errs++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				awaited_results.push_back(deframe(in_byte));
			end
			results_owed <= awaited_results.size();
			mismatches   <= mismatches + errs;
		end
	end

endmodule

FILE: sim/sync_length_frame_receiver_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sync_length_frame_receiver_tb
// Drives the frame receiver with directed preambles, mismatches and short
// frames, one long frame, then random frames, broken preambles and
// line noise under several register settings, with random idling on both
// sides. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module sync_length_frame_receiver_tb;
	import slfr_pkg::*;

	localparam int IdleLimit   = 1000;
	localparam int RandomItems = 480;
	localparam int QuietFrom   = 400;
	localparam int PhaseItems  = 100;
	localparam int LongSize    = 260;
	localparam logic [CfgIdxW-1:0] FirstUnusedReg = REG_SIZE_BIG_ENDIAN + 1'b1;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic [ByteW-1:0]   cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [ByteW-1:0]   in_byte;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [ByteW-1:0]   out_byte;
	logic               in_frame;
	logic [PosW-1:0]    frame_pos;
	logic               frame_last;
	int                 results_owed;
	int                 mismatches;

	// Idling controls
	int   gap_pct     = 0;
	int   stall_pct   = 0;
	logic quiet       = 1'b0;
	int   stall_left  = 0;
	int   idle_cycles = 0;
	int   sent        = 0;

	// Current settings, used to build well-formed frames, broken preambles and noise
	logic [ByteW-1:0] cur_sync1 = SyncFirstRst;
	logic [ByteW-1:0] cur_sync2 = SyncSecondRst;
	logic [HdrW-1:0]  cur_hdr   = HeaderBytesRst;
	logic             cur_be    = SizeBigEndianRst;

	sync_length_frame_receiver DUT (.*);

	sync_length_frame_receiver_checker deframe_check (.*);

	always #5 clk = ~clk;

	// Stall the result side in random bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
			stall_left <= $urandom_range(0, 10);
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
		    (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IdleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Present one byte, maybe after a gap, and hold it until taken
	task automatic send(input logic [ByteW-1:0] b);
		int n;
		if (!quiet && $urandom_range(0, 99) < gap_pct) begin
			n = $urandom_range(1, 11);
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	// Hold off input until every predicted result has left the block
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Program all registers while idle; spare upper data bits are random
	task automatic configure(input logic [ByteW-1:0] s1, input logic [ByteW-1:0] s2,
	                         input logic [HdrW-1:0] hdr, input logic be);
		logic [31:0]           rnd;
		logic [ByteW-HdrW-1:0] hdr_pad;
		logic [ByteW-2:0]      be_pad;
		logic [CfgIdxW-1:0]    bogus_idx;
		logic [ByteW-1:0]      bogus_val;
		rnd       = $urandom;
		hdr_pad   = rnd[ByteW-HdrW-1:0];
		rnd       = $urandom;
		be_pad    = rnd[ByteW-2:0];
		bogus_idx = 8'($urandom_range(FirstUnusedReg, 255));
		bogus_val = 8'($urandom);
		drain();
		write_reg(REG_SYNC_FIRST, s1);
		write_reg(REG_SYNC_SECOND, s2);
		write_reg(REG_HEADER_BYTES, {hdr_pad, hdr});
		write_reg(REG_SIZE_BIG_ENDIAN, {be_pad, be});
		write_reg(bogus_idx, bogus_val);
		cfg_valid <= 1'b0;
		cur_sync1 = s1;
		cur_sync2 = s2;
		cur_hdr   = hdr;
		cur_be    = be;
	endtask

	// Well-formed frame with random body
	task automatic send_frame(input int size);
		logic [15:0] sz;
		int total;
		int k;
		sz    = 16'(size);
		total = size + cur_hdr;
		send(cur_sync1);
		send(cur_sync2);
		if (cur_be) begin
			send(sz[15:8]);
			send(sz[7:0]);
		end else begin
			send(sz[7:0]);
			send(sz[15:8]);
		end
		for (k = PosData; k < total; k++) send(8'($urandom));
	endtask

	// Random byte that cannot open a frame
	function automatic logic [ByteW-1:0] noise_byte();
		logic [ByteW-1:0] b;
		b = 8'($urandom);
		if (b == cur_sync1) b = b ^ 8'h01;
		return b;
	endfunction

	initial begin
		int rand_start;
		int phase_start;
		int phase_no;
		int sel;
		int size;
		logic [ByteW-1:0] s1;
		logic [ByteW-1:0] s2;
		logic [HdrW-1:0]  hdr;
		logic [ByteW-1:0] bad;
		int pct_list[4];

		pct_list = '{0, 5, 20, 50};
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		in_byte   = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: noise, sync mismatch, one short-bodied frame
		gap_pct = 20;
		stall_pct <= 20;
		send(8'hFF);
		send(8'h02);
		send(8'h03);
		send(8'h02);
		send(8'h02);
		send(8'h00);
		send(8'h01);
		send(8'hFF);
		send(8'h00);
		send(8'h80);
		send(8'h7F);

		// Extreme sync values, zero header, little-endian size
		configure(8'hFF, 8'h00, 5'd0, 1'b0);
		// second byte matches the first sync value only: dropped, not restarted
		send(8'hFF);
		send(8'hFF);
		send(8'h00);
		// total three and total four end on the second size byte
		send(8'hFF);
		send(8'h00);
		send(8'h03);
		send(8'h00);
		send(8'hFF);
		send(8'h00);
		send(8'h04);
		send(8'h00);
		// total five carries one body byte
		send(8'hFF);
		send(8'h00);
		send(8'h05);
		send(8'h00);
		send(8'hAA);

		// Long frame: size past one byte with the widest header
		s1 = 8'($urandom);
		s2 = 8'($urandom);
		configure(s1, s2, 5'd31, 1'b1);
		gap_pct = 5;
		stall_pct <= 5;
		send_frame(LongSize);

		// Random frames, broken preambles and noise over several settings
		rand_start = sent;
		phase_no   = 0;
		while (sent - rand_start < RandomItems) begin
			s1 = 8'($urandom);
			s2 = ($urandom_range(0, 3) == 0) ? s1 : 8'($urandom);
			case (phase_no % 5)
				0:       hdr = 5'd4;
				1:       hdr = 5'd16;
				2:       hdr = 5'd0;
				3:       hdr = 5'd31;
				default: hdr = 5'($urandom);
			endcase
			configure(s1, s2, hdr, phase_no[0]);
			gap_pct = pct_list[$urandom_range(0, 3)];
			stall_pct <= pct_list[$urandom_range(0, 3)];
			phase_start = sent;
			while (sent - phase_start < PhaseItems && sent - rand_start < RandomItems) begin
				quiet <= (sent - rand_start) >= QuietFrom;
				sel = $urandom_range(0, 99);
				if (sel < 80) begin
					size = ($urandom_range(0, 99) < 2) ? $urandom_range(256, 400)
					                                   : $urandom_range(0, 40);
					send_frame(size);
				end else if (sel < 90) begin
					// first sync followed by a wrong second byte
					bad = 8'($urandom);
					if (bad == cur_sync2) bad = bad ^ 8'h80;
					send(cur_sync1);
					send(bad);
				end else begin
					repeat ($urandom_range(1, 6)) send(noise_byte());
				end
			end
			phase_no++;
		end

		drain();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && results_owed == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
